### hdl/assert_macros.svh
// Assertion macros for the checker module of the radix-to-text block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger.
`define SRT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that a condition holds in the cycle after its trigger.
`define SRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/srtt_pkg.sv
// Shared constants, types and helpers of the radix-to-text block.
`timescale 1ns / 1ps
`default_nettype none
package srtt_pkg;

    localparam int MAX_SYMBOLS = 32;
    localparam int SYM_W       = 8;
    localparam int IDX_W       = $clog2(MAX_SYMBOLS);
    localparam int LEN_W       = 6;
    localparam int VAL_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int ALPHA_W     = MAX_SYMBOLS * SYM_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_3  = 3'd4;

    // Register reset values: decimal alphabet "0123456789"
    localparam logic [LEN_W-1:0]      RST_BASE_LEN = 6'd10;
    localparam logic [CFG_DATA_W-1:0] RST_ALPHA_0  = 64'h3736_3534_3332_3130;
    localparam logic [CFG_DATA_W-1:0] RST_ALPHA_1  = 64'h0000_0000_0000_3938;
    localparam logic [CFG_DATA_W-1:0] RST_ALPHA_2  = 64'h0;
    localparam logic [CFG_DATA_W-1:0] RST_ALPHA_3  = 64'h0;

    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;

    // Result of the alphabet check
    typedef struct packed {
        logic done;
        logic ok;
    } t_chk_res;

    // Result of one division step sequence
    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] quot;
        logic [IDX_W-1:0] rem;
    } t_div_res;

    // Pick one symbol byte out of the flat alphabet
    function automatic logic [SYM_W-1:0] sym_at(input logic [ALPHA_W-1:0] alpha,
                                                input logic [IDX_W-1:0]   idx);
        return alpha[{idx, 3'b000} +: SYM_W];
    endfunction

endpackage
`default_nettype wire

### hdl/signed_radix_to_text.sv
// Top level: converts a signed 32-bit value to text in a configurable radix.
//
//   channel   direction  ports                               handshake
//   request   in         i_value                             start & !busy
//   result    out        o_char_out, o_final_char            o_valid, one cycle
//   config    in         i_cfg_idx, i_cfg_data               i_cfg_we
//
// A request checks the alphabet, emits a minus sign for a negative value, then
// runs the divider once per digit, storing each remainder, and reads the digits
// out most significant first. The shared divider makes one quotient bit per
// cycle; busy drops as the last character goes out. An invalid alphabet ends
// the request after the check with no characters. Reset is synchronous; the
// receiver cannot stall the results.
`timescale 1ns / 1ps
`default_nettype none
module signed_radix_to_text (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic signed [31:0]             i_value,
    input  wire logic                           i_cfg_we,
    input  wire logic [srtt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [srtt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                                o_valid,
    output logic [7:0]                          o_char_out,
    output logic                                o_final_char
);
    import srtt_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_SIGN  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [LEN_W-1:0]      r_base_len;
    logic [CFG_DATA_W-1:0] r_alpha0, r_alpha1, r_alpha2, r_alpha3;
    logic [ALPHA_W-1:0]    w_alpha;
    logic                  r_neg, n_neg;
    logic [VAL_W-1:0]      r_mag, n_mag;
    logic [IDX_W-1:0]      r_nd, n_nd;
    logic [IDX_W-1:0]      r_k, n_k;
    logic [IDX_W-1:0]      r_buf [MAX_SYMBOLS];
    logic                  w_buf_we;
    logic                  r_valid, n_valid;
    logic [SYM_W-1:0]      r_char, n_char;
    logic                  r_final, n_final;
    logic                  w_accept;
    logic                  w_div_go;
    logic [VAL_W-1:0]      w_dividend;
    t_chk_res              w_chk;
    t_div_res              w_div;

    assign w_alpha  = {r_alpha3, r_alpha2, r_alpha1, r_alpha0};
    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;

    // Hold the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_len <= RST_BASE_LEN;
            r_alpha0   <= RST_ALPHA_0;
            r_alpha1   <= RST_ALPHA_1;
            r_alpha2   <= RST_ALPHA_2;
            r_alpha3   <= RST_ALPHA_3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BASE_LEN: r_base_len <= i_cfg_data[LEN_W-1:0];
                REG_ALPHA_0:  r_alpha0   <= i_cfg_data;
                REG_ALPHA_1:  r_alpha1   <= i_cfg_data;
                REG_ALPHA_2:  r_alpha2   <= i_cfg_data;
                REG_ALPHA_3:  r_alpha3   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    srtt_chk u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (w_accept),
        .i_base_len (r_base_len),
        .i_alpha    (w_alpha),
        .o_res      (w_chk)
    );

    // Feed the divider the magnitude first, then each quotient
    assign w_dividend = (r_state == ST_SIGN) ? r_mag : w_div.quot;
    assign w_div_go   = (r_state == ST_SIGN) ||
                        ((r_state == ST_DIV) && w_div.done &&
                         (w_div.quot != '0) && (r_nd != IDX_W'(MAX_SYMBOLS - 1)));
    assign w_buf_we   = (r_state == ST_DIV) && w_div.done;

    srtt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (w_div_go),
        .i_dividend (w_dividend),
        .i_divisor  (r_base_len),
        .o_res      (w_div)
    );

    // Sequence check, sign, digit generation and readout
    always_comb begin
        n_state = r_state;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_nd    = r_nd;
        n_k     = r_k;
        n_valid = 1'b0;
        n_char  = r_char;
        n_final = r_final;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_neg   = i_value[VAL_W-1];
                    n_mag   = i_value[VAL_W-1] ? (VAL_W'(0) - VAL_W'(i_value))
                                               : VAL_W'(i_value);
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (w_chk.done) begin
                    n_state = w_chk.ok ? ST_SIGN : ST_IDLE;
                end
            end
            ST_SIGN: begin
                n_valid = r_neg;
                n_char  = CH_MINUS;
                n_final = 1'b0;
                n_nd    = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (w_div.done) begin
                    if (w_div_go) begin
                        n_nd = r_nd + IDX_W'(1);
                    end else begin
                        n_k     = r_nd;
                        n_state = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                n_valid = 1'b1;
                n_char  = sym_at(w_alpha, r_buf[r_k]);
                n_final = (r_k == '0);
                if (r_k == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_k = r_k - IDX_W'(1);
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_neg   <= n_neg;
        r_mag   <= n_mag;
        r_nd    <= n_nd;
        r_k     <= n_k;
        r_char  <= n_char;
        r_final <= n_final;
    end

    // Store each remainder digit, least significant first
    always_ff @(posedge i_clk) begin
        if (w_buf_we) begin
            r_buf[r_nd] <= w_div.rem;
        end
    end

    assign o_valid      = r_valid;
    assign o_char_out   = r_char;
    assign o_final_char = r_final;

endmodule
`default_nettype wire

### hdl/srtt_chk.sv
// Alphabet checker: walks the symbols one per cycle looking for signs and repeats.
`timescale 1ns / 1ps
`default_nettype none
module srtt_chk (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_go,
    input  wire logic [5:0]              i_base_len,
    input  wire logic [255:0]            i_alpha,
    output srtt_pkg::t_chk_res           o_res
);
    import srtt_pkg::*;

    logic             r_busy, n_busy;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_done, n_done;
    logic             r_ok, n_ok;
    logic [SYM_W-1:0] w_cur;
    logic             w_dup;
    logic             w_sign;
    logic             w_last;
    logic             w_len_ok;

    assign w_cur    = sym_at(i_alpha, r_idx);
    assign w_sign   = (w_cur == CH_PLUS) || (w_cur == CH_MINUS);
    assign w_last   = ({1'b0, r_idx} == (i_base_len - 6'd1));
    assign w_len_ok = (i_base_len >= 6'd2) && (i_base_len <= LEN_W'(MAX_SYMBOLS));

    // Compare the current symbol against every later symbol in use
    always_comb begin
        w_dup = 1'b0;
        for (int j = 0; j < MAX_SYMBOLS; j++) begin
            if ((j > int'(r_idx)) && (j < int'(i_base_len)) &&
                (sym_at(i_alpha, IDX_W'(j)) == w_cur)) begin
                w_dup = 1'b1;
            end
        end
    end

    // Advance the walk; stop at the first bad symbol or the last one
    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        n_done = 1'b0;
        n_ok   = r_ok;
        if (i_go) begin
            n_idx = '0;
            if (w_len_ok) begin
                n_busy = 1'b1;
            end else begin
                n_done = 1'b1;
                n_ok   = 1'b0;
            end
        end else if (r_busy) begin
            if (w_sign || w_dup) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                n_ok   = 1'b0;
            end else if (w_last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                n_ok   = 1'b1;
            end else begin
                n_idx = r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_idx <= n_idx;
        r_ok  <= n_ok;
    end

    assign o_res.done = r_done;
    assign o_res.ok   = r_ok;

endmodule
`default_nettype wire

### hdl/srtt_div.sv
// Shared restoring divider: one quotient bit per cycle, divisor up to 32.
`timescale 1ns / 1ps
`default_nettype none
module srtt_div (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_go,
    input  wire logic [31:0]             i_dividend,
    input  wire logic [5:0]              i_divisor,
    output srtt_pkg::t_div_res           o_res
);
    import srtt_pkg::*;

    localparam int CNT_W = $clog2(VAL_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [VAL_W-1:0] r_q, n_q;
    logic [IDX_W-1:0] r_rem, n_rem;
    logic [LEN_W-1:0] r_dsr, n_dsr;
    logic [LEN_W-1:0] w_trial;
    logic             w_fit;

    // Shift in the next dividend bit and try the subtract
    assign w_trial = {r_rem, r_q[VAL_W-1]};
    assign w_fit   = (w_trial >= r_dsr);

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        if (i_go) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_dividend;
            n_rem  = '0;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            n_q   = {r_q[VAL_W-2:0], w_fit};
            n_rem = w_fit ? IDX_W'(w_trial - r_dsr) : IDX_W'(w_trial);
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(VAL_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_q;
    assign o_res.rem  = r_rem;

endmodule
`default_nettype wire

### hdl/srtt_sva.sv
// Port-level checker for the radix-to-text block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module srtt_sva (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid,
    input wire logic o_final_char
);

    // A character only comes out of a request in flight
    `SRT_ASSERT_NOW(a_valid_in_request, i_clk, i_rst_n, o_valid, $past(busy))
    // An accepted request makes the block busy
    `SRT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // The last character ends the burst
    `SRT_ASSERT_NEXT(a_final_ends, i_clk, i_rst_n, o_valid && o_final_char, !o_valid)
    // A character that is not the last shows while the request is still open
    `SRT_ASSERT_NOW(a_more_follow, i_clk, i_rst_n, o_valid && !o_final_char, busy)
    // An idle block with no request stays quiet
    `SRT_ASSERT_NEXT(a_idle_quiet, i_clk, i_rst_n, !busy, !o_valid)

endmodule

bind signed_radix_to_text srtt_sva u_srtt_sva (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_final_char (o_final_char)
);
`default_nettype wire
